FILE: rtl/core/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Shared widths, limits, controller states and the command and status words
// passed between the block average error estimator controller and datapath.
// ----------------------------------------------------------------------------
package bae_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int BSIZE_W     = 11;
   localparam int DEV_W       = 16;
   localparam int MAX_SAMPLES = 4096;
   localparam int MAX_BLOCK   = 1024;
   localparam int POS_W       = 10;
   localparam int BSUM_W      = 26;
   localparam int MAG_W       = 26;
   localparam int PROD_W      = 52;
   localparam int S1_W        = 29;
   localparam int S1MAG_W     = 28;
   localparam int S1SQ_W      = 56;
   localparam int S2_W        = 53;
   localparam int CNT_W       = 13;
   localparam int NG_W        = 24;
   localparam int WIDE_W      = 64;
   localparam int STEP_W      = 6;
   localparam int MUL_STEPS   = 13;
   localparam int DIV_STEPS   = 64;
   localparam int SQRT_STEPS  = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PREP,
      ST_NUM,
      ST_DEN_LOAD,
      ST_DEN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic square;
      logic accum;
      logic prep;
      logic mul_step;
      logic den_load;
      logic div_load;
      logic div_step;
      logic sqrt_load;
      logic sqrt_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic closes;
      logic last;
      logic few_blocks;
   } sts_type;

endpackage

FILE: rtl/core/bae_intf.sv
// ----------------------------------------------------------------------------
// bae channel interfaces
// Valid/ready channels for sample words, result words and block size writes.
// ----------------------------------------------------------------------------
interface bae_sample_if;
   logic                               valid;
   logic                               ready;
   logic signed [bae_pkg::SAMPLE_W-1:0] sample;
   logic                               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface bae_result_if;
   logic                         valid;
   logic                         ready;
   logic [bae_pkg::DEV_W-1:0]    deviation;
   logic                         status;

   modport source (output valid, output deviation, output status, input ready);
   modport sink   (input valid, input deviation, input status, output ready);
endinterface

interface bae_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bae_pkg::BSIZE_W-1:0]  block_size;

   modport source (output valid, output block_size, input ready);
   modport sink   (input valid, input block_size, output ready);
endinterface

FILE: rtl/core/block_average_error_estimator.sv
// ----------------------------------------------------------------------------
// block_average_error_estimator
// Blocking-method standard error of a stream of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Channels: req_ch carries sample words (sample, last), rsp_ch one result word
// (deviation, status) per series, csr_ch writes block_size; csr_ch is always
// ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A sample that closes a block holds off the
// input through the square and accumulate states: the 26 x 26 bit square of
// the block sum is registered before it is added to the sum of squares.
// The word marked last starts the final sequence: two 13 step shift-add
// multiplies, a 64 step restoring divider and a 32 step integer square root,
// one step per cycle. Fewer than two complete blocks skips all of it and
// gives status 1. The result word sits in an output register; new samples
// are taken while it waits, and only the next result holds back until
// rsp_ch accepts the previous one.
// Reset clears the series and the result valid, and sets block_size to 1.
// ----------------------------------------------------------------------------
module block_average_error_estimator (
   input  logic                  clock,
   input  logic                  reset,
   bae_sample_if.sink            req_ch,
   bae_result_if.source          rsp_ch,
   bae_csr_if.sink               csr_ch
);

   bae_pkg::cmd_type cmd;
   bae_pkg::sts_type sts;

   assign csr_ch.ready = 1'b1;

   bae_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bae_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .sample         (req_ch.sample),
      .last           (req_ch.last),
      .csr_we         (csr_ch.valid),
      .csr_block_size (csr_ch.block_size),
      .deviation      (rsp_ch.deviation),
      .status         (rsp_ch.status)
   );

endmodule

FILE: rtl/core/bae_datapath.sv
// ----------------------------------------------------------------------------
// bae_datapath
// Block accumulators, shift-add multiplier, restoring divider, integer square
// root and the result register, all stepped by the controller's commands.
// ----------------------------------------------------------------------------
module bae_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  bae_pkg::cmd_type                    cmd,
   output bae_pkg::sts_type                    sts,
   input  logic signed [bae_pkg::SAMPLE_W-1:0] sample,
   input  logic                                last,
   input  logic                                csr_we,
   input  logic [bae_pkg::BSIZE_W-1:0]         csr_block_size,
   output logic [bae_pkg::DEV_W-1:0]           deviation,
   output logic                                status
);

   logic [bae_pkg::BSIZE_W-1:0]  block_size_ff;
   logic [bae_pkg::BSIZE_W-1:0]  g_eff;
   logic [bae_pkg::BSIZE_W-1:0]  g_ff;

   logic [bae_pkg::CNT_W-1:0]    accepted_ff;
   logic signed [bae_pkg::BSUM_W-1:0] bsum_ff;
   logic [bae_pkg::POS_W-1:0]    pos_ff;
   logic signed [bae_pkg::S1_W-1:0] s1_ff;
   logic [bae_pkg::S2_W-1:0]     s2_ff;
   logic [bae_pkg::CNT_W-1:0]    count_ff;

   logic                         full;
   logic signed [bae_pkg::BSUM_W-1:0] bsum_in;
   logic [bae_pkg::BSUM_W-1:0]   bsum_neg;
   logic [bae_pkg::MAG_W-1:0]    mag_ff;
   logic [bae_pkg::PROD_W-1:0]   prod_ff;

   logic [bae_pkg::S1_W-1:0]     s1_neg;
   logic [bae_pkg::S1MAG_W-1:0]  s1_mag;
   logic [bae_pkg::S1SQ_W-1:0]   s1sq_ff;
   logic [bae_pkg::NG_W-1:0]     ng_ff;
   logic [2*bae_pkg::NG_W-1:0]   ng_sq;

   logic [bae_pkg::WIDE_W-1:0]   mul_a_ff;
   logic [bae_pkg::CNT_W-1:0]    mul_b_ff;
   logic [bae_pkg::WIDE_W-1:0]   mul_acc_ff;
   logic [bae_pkg::WIDE_W-1:0]   num_ff;
   logic [bae_pkg::WIDE_W-1:0]   s1sq_wide;

   logic [bae_pkg::WIDE_W-1:0]   quo_ff;
   logic [bae_pkg::WIDE_W-1:0]   rem_ff;
   logic [bae_pkg::WIDE_W-1:0]   den_ff;
   logic [bae_pkg::WIDE_W:0]     rem_sh;
   logic [bae_pkg::WIDE_W:0]     rem_diff;

   logic [bae_pkg::WIDE_W-1:0]   sv_ff;
   logic [bae_pkg::WIDE_W-1:0]   root_ff;
   logic [bae_pkg::WIDE_W-1:0]   bit_ff;
   logic [bae_pkg::WIDE_W-1:0]   trial;

   logic [bae_pkg::DEV_W-1:0]    dev_ff;
   logic                         status_ff;

   // effective block size: zero counts as one, larger than the maximum saturates
   always_comb begin
      if (block_size_ff == '0) begin
         g_eff = bae_pkg::BSIZE_W'(1);
      end else if (block_size_ff > bae_pkg::BSIZE_W'(bae_pkg::MAX_BLOCK)) begin
         g_eff = bae_pkg::BSIZE_W'(bae_pkg::MAX_BLOCK);
      end else begin
         g_eff = block_size_ff;
      end
   end

   assign full     = (accepted_ff == bae_pkg::CNT_W'(bae_pkg::MAX_SAMPLES));
   assign bsum_in  = bsum_ff + {{(bae_pkg::BSUM_W - bae_pkg::SAMPLE_W){sample[bae_pkg::SAMPLE_W-1]}},
                                sample};
   assign bsum_neg = '0 - bsum_in;
   assign s1_neg   = '0 - s1_ff;
   assign s1_mag   = s1_ff[bae_pkg::S1_W-1] ? s1_neg[bae_pkg::S1MAG_W-1:0]
                                            : s1_ff[bae_pkg::S1MAG_W-1:0];
   assign s1sq_wide = bae_pkg::WIDE_W'(s1sq_ff);
   assign ng_sq     = ng_ff * ng_ff;

   assign sts.closes     = !full &&
                           ((bae_pkg::BSIZE_W'(pos_ff) + bae_pkg::BSIZE_W'(1)) >= g_eff);
   assign sts.last       = last;
   assign sts.few_blocks = (count_ff < bae_pkg::CNT_W'(2));

   assign rem_sh   = {rem_ff, quo_ff[bae_pkg::WIDE_W-1]};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign trial    = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= bae_pkg::BSIZE_W'(1);
      end else if (csr_we) begin
         block_size_ff <= csr_block_size;
      end
   end

   // series accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= '0;
         bsum_ff     <= '0;
         pos_ff      <= '0;
         s1_ff       <= '0;
         s2_ff       <= '0;
         count_ff    <= '0;
      end else if (cmd.emit) begin
         accepted_ff <= '0;
         bsum_ff     <= '0;
         pos_ff      <= '0;
         s1_ff       <= '0;
         s2_ff       <= '0;
         count_ff    <= '0;
      end else begin
         if (cmd.accept && !full) begin
            accepted_ff <= accepted_ff + bae_pkg::CNT_W'(1);
            if (sts.closes) begin
               s1_ff    <= s1_ff + {{(bae_pkg::S1_W - bae_pkg::BSUM_W){bsum_in[bae_pkg::BSUM_W-1]}},
                                    bsum_in};
               count_ff <= count_ff + bae_pkg::CNT_W'(1);
               bsum_ff  <= '0;
               pos_ff   <= '0;
            end else begin
               bsum_ff  <= bsum_in;
               pos_ff   <= pos_ff + bae_pkg::POS_W'(1);
            end
         end
         if (cmd.accum) begin
            s2_ff <= s2_ff + bae_pkg::S2_W'(prod_ff);
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         g_ff   <= g_eff;
         mag_ff <= bsum_in[bae_pkg::BSUM_W-1] ? bsum_neg : bsum_in;
      end
      if (cmd.square) begin
         prod_ff <= mag_ff * mag_ff;
      end
      if (cmd.prep) begin
         s1sq_ff    <= s1_mag * s1_mag;
         ng_ff      <= bae_pkg::NG_W'(count_ff) * bae_pkg::NG_W'(g_ff);
         mul_a_ff   <= bae_pkg::WIDE_W'(s2_ff);
         mul_b_ff   <= count_ff;
         mul_acc_ff <= '0;
      end else if (cmd.den_load) begin
         num_ff     <= (mul_acc_ff >= s1sq_wide) ? (mul_acc_ff - s1sq_wide) : '0;
         mul_a_ff   <= bae_pkg::WIDE_W'(ng_sq);
         mul_b_ff   <= count_ff - bae_pkg::CNT_W'(1);
         mul_acc_ff <= '0;
      end else if (cmd.mul_step) begin
         if (mul_b_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_a_ff;
         end
         mul_a_ff <= {mul_a_ff[bae_pkg::WIDE_W-2:0], 1'b0};
         mul_b_ff <= {1'b0, mul_b_ff[bae_pkg::CNT_W-1:1]};
      end
      if (cmd.div_load) begin
         quo_ff <= num_ff;
         rem_ff <= '0;
         den_ff <= mul_acc_ff;
      end else if (cmd.div_step) begin
         if (!rem_diff[bae_pkg::WIDE_W]) begin
            rem_ff <= rem_diff[bae_pkg::WIDE_W-1:0];
            quo_ff <= {quo_ff[bae_pkg::WIDE_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[bae_pkg::WIDE_W-1:0];
            quo_ff <= {quo_ff[bae_pkg::WIDE_W-2:0], 1'b0};
         end
      end
      if (cmd.sqrt_load) begin
         sv_ff   <= quo_ff;
         root_ff <= '0;
         bit_ff  <= {2'b01, {(bae_pkg::WIDE_W-2){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if (sv_ff >= trial) begin
            sv_ff   <= sv_ff - trial;
            root_ff <= {1'b0, root_ff[bae_pkg::WIDE_W-1:1]} + bit_ff;
         end else begin
            root_ff <= {1'b0, root_ff[bae_pkg::WIDE_W-1:1]};
         end
         bit_ff <= {2'b00, bit_ff[bae_pkg::WIDE_W-1:2]};
      end
      if (cmd.emit) begin
         status_ff <= sts.few_blocks;
         if (sts.few_blocks) begin
            dev_ff <= '0;
         end else if (root_ff[bae_pkg::WIDE_W-1:bae_pkg::DEV_W] != '0) begin
            dev_ff <= '1;
         end else begin
            dev_ff <= root_ff[bae_pkg::DEV_W-1:0];
         end
      end
   end

   assign deviation = dev_ff;
   assign status    = status_ff;

endmodule

FILE: rtl/core/bae_controller.sv
// ----------------------------------------------------------------------------
// bae_controller
// Sequencer: takes sample words, orders the block square-accumulate and the
// final multiply, divide and square root steps, and holds the result valid.
// ----------------------------------------------------------------------------
module bae_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bae_pkg::sts_type  sts,
   output bae_pkg::cmd_type  cmd
);

   bae_pkg::state_type           state_ff, state_in;
   logic [bae_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                         last_ff, last_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bae_pkg::ST_IDLE;
         step_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         bae_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               last_in    = sts.last;
               if (sts.closes) begin
                  state_in = bae_pkg::ST_SQUARE;
               end else if (sts.last) begin
                  state_in = bae_pkg::ST_PREP;
               end
            end
         end
         bae_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = bae_pkg::ST_ACCUM;
         end
         bae_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = last_ff ? bae_pkg::ST_PREP : bae_pkg::ST_IDLE;
         end
         bae_pkg::ST_PREP: begin
            if (sts.few_blocks) begin
               state_in = bae_pkg::ST_EMIT;
            end else begin
               cmd.prep = 1'b1;
               step_in  = bae_pkg::STEP_W'(bae_pkg::MUL_STEPS - 1);
               state_in = bae_pkg::ST_NUM;
            end
         end
         bae_pkg::ST_NUM: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - bae_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = bae_pkg::ST_DEN_LOAD;
            end
         end
         bae_pkg::ST_DEN_LOAD: begin
            cmd.den_load = 1'b1;
            step_in      = bae_pkg::STEP_W'(bae_pkg::MUL_STEPS - 1);
            state_in     = bae_pkg::ST_DEN;
         end
         bae_pkg::ST_DEN: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - bae_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = bae_pkg::ST_DIV_LOAD;
            end
         end
         bae_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = bae_pkg::STEP_W'(bae_pkg::DIV_STEPS - 1);
            state_in     = bae_pkg::ST_DIV;
         end
         bae_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - bae_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = bae_pkg::ST_SQRT_LOAD;
            end
         end
         bae_pkg::ST_SQRT_LOAD: begin
            cmd.sqrt_load = 1'b1;
            step_in       = bae_pkg::STEP_W'(bae_pkg::SQRT_STEPS - 1);
            state_in      = bae_pkg::ST_SQRT;
         end
         bae_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff - bae_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = bae_pkg::ST_EMIT;
            end
         end
         bae_pkg::ST_EMIT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               last_in      = 1'b0;
               state_in     = bae_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bae_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the block average error estimator. Sample words are
// driven from a backlog with random gaps; the block sums, sums of squares and
// block count are tracked alongside to work out the standard error of the
// block means at every last word, and each result word is compared with it.
// Block size changes between series and mid-series, a long result hold-off
// and full-rate bursts are all exercised.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 160;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 780;

   localparam logic signed [bae_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
      {1'b0, {(bae_pkg::SAMPLE_W-1){1'b1}}};
   localparam logic signed [bae_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
      {1'b1, {(bae_pkg::SAMPLE_W-1){1'b0}}};

   typedef enum logic [1:0] {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGE} spread_type;

   typedef struct packed {
      logic signed [bae_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } sample_word_type;

   typedef struct packed {
      logic [bae_pkg::DEV_W-1:0] deviation;
      logic                      status;
   } std_err_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bae_sample_if req_ch ();
   bae_result_if rsp_ch ();
   bae_csr_if    csr_ch ();

   block_average_error_estimator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sample_word_type sample_backlog[$];
   std_err_type     std_err_q[$];

   // shadow of the block's series state
   logic [bae_pkg::BSIZE_W-1:0] size_reg = bae_pkg::BSIZE_W'(1);
   longint             blk_sum  = 0;
   longint unsigned    blk_pos  = 0;
   longint             sum_blk  = 0;
   longint unsigned    sum_sq   = 0;
   longint unsigned    blk_cnt  = 0;
   longint unsigned    taken    = 0;

   int          errors        = 0;
   int          queued_items  = 0;
   int unsigned send_gap_max  = 10;
   int unsigned recv_gap_max  = 10;
   int unsigned send_idle     = 0;
   int unsigned recv_stall    = 0;
   int          quiet         = 0;
   bit          hold_request  = 1'b0;
   bit          hold_taken    = 1'b0;
   int unsigned hold_left     = 0;

   function automatic int unsigned eff_size();
      if (size_reg == 0)
         return 1;
      if (size_reg > bae_pkg::MAX_BLOCK)
         return bae_pkg::MAX_BLOCK;
      return size_reg;
   endfunction

   task automatic accumulate_sample(input logic signed [bae_pkg::SAMPLE_W-1:0] x,
                                    input logic is_last);
      longint unsigned g, n, m, s1m, num, sq, ng, den, root, t;
      std_err_type     r;
      g = eff_size();
      if (taken < bae_pkg::MAX_SAMPLES) begin
         taken++;
         blk_sum += longint'(x);
         if (blk_pos + 1 >= g) begin
            m = (blk_sum < 0) ? -blk_sum : blk_sum;
            sum_blk += blk_sum;
            sum_sq  += m * m;
            blk_cnt++;
            blk_sum = 0;
            blk_pos = 0;
         end else begin
            blk_pos++;
         end
      end
      if (is_last) begin
         if (blk_cnt < 2) begin
            r.deviation = '0;
            r.status    = 1'b1;
         end else begin
            n   = blk_cnt;
            s1m = (sum_blk < 0) ? -sum_blk : sum_blk;
            num = n * sum_sq;
            sq  = s1m * s1m;
            ng  = n * g;
            den = (n - 1) * ng * ng;
            num = (num >= sq) ? num - sq : 0;
            num = num / den;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
               t = root | (64'd1 << b);
               if (t * t <= num)
                  root = t;
            end
            r.deviation = (root > 64'hFFFF) ? '1 : root[bae_pkg::DEV_W-1:0];
            r.status    = 1'b0;
         end
         std_err_q.push_back(r);
         blk_sum = 0;
         blk_pos = 0;
         sum_blk = 0;
         sum_sq  = 0;
         blk_cnt = 0;
         taken   = 0;
      end
   endtask

   // driver
   always @(posedge clock) begin : sample_driver
      sample_word_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_idle    <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            accumulate_sample(req_ch.sample, req_ch.last);
         if (!req_ch.valid || req_ch.ready) begin
            if (send_idle != 0) begin
               req_ch.valid <= 1'b0;
               send_idle    <= send_idle - 1;
            end else if (sample_backlog.size() != 0) begin
               w = sample_backlog.pop_front();
               req_ch.valid  <= 1'b1;
               req_ch.sample <= w.sample;
               req_ch.last   <= w.last;
               send_idle     <= $urandom_range(0, send_gap_max);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_monitor
      int unsigned stall;
      std_err_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall   <= 0;
      end else begin
         stall = recv_stall;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (std_err_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result word: deviation %0d status %0d",
                           rsp_ch.deviation, rsp_ch.status);
               errors++;
            end else begin
               want = std_err_q.pop_front();
               if (rsp_ch.deviation !== want.deviation || rsp_ch.status !== want.status) begin
                  if (errors < 10)
                     $display("mismatch: deviation exp %0d got %0d, status exp %0d got %0d",
                              want.deviation, rsp_ch.deviation, want.status, rsp_ch.status);
                  errors++;
               end
            end
            stall = $urandom_range(0, recv_gap_max);
         end else if (stall != 0) begin
            stall--;
         end
         recv_stall   <= stall;
         rsp_ch.ready <= (stall == 0) && (hold_left == 0);
      end
   end

   // one long result hold-off, so the block fills up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_ch.valid && csr_ch.ready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic signed [bae_pkg::SAMPLE_W-1:0] draw_sample(
      input spread_type sp, input logic signed [bae_pkg::SAMPLE_W-1:0] centre);
      case (sp)
         SPREAD_NARROW: return centre + bae_pkg::SAMPLE_W'($urandom_range(0, 64))
                               - bae_pkg::SAMPLE_W'(32);
         SPREAD_EDGE:   return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         default:       return bae_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_sample(input logic signed [bae_pkg::SAMPLE_W-1:0] s, input logic l);
      sample_word_type w;
      w.sample = s;
      w.last   = l;
      sample_backlog.push_back(w);
      queued_items++;
   endtask

   task automatic send_series(input int unsigned blocks, input int unsigned tail,
                              input logic close);
      int unsigned                         total;
      spread_type                          sp;
      logic signed [bae_pkg::SAMPLE_W-1:0] centre;
      total = blocks * eff_size() + tail;
      if (total == 0)
         total = 1;
      sp     = spread_type'($urandom_range(0, 2));
      centre = bae_pkg::SAMPLE_W'($urandom);
      for (int unsigned i = 1; i <= total; i++)
         queue_sample(draw_sample(sp, centre), close && i == total);
   endtask

   task automatic write_block_size(input logic [bae_pkg::BSIZE_W-1:0] v);
      @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.block_size <= v;
      do @(negedge clock);
      while (!csr_ch.ready);
      @(posedge clock);
      csr_ch.valid <= 1'b0;
      size_reg = v;
      @(negedge clock);
   endtask

   // wait for every word to be taken and every result to arrive, then settle
   task automatic drain();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_ch.valid || std_err_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [bae_pkg::BSIZE_W-1:0] new_size;
      int unsigned                 n_series, blocks, tail;
      int                          random_start;
      req_ch.valid      = 1'b0;
      req_ch.sample     = '0;
      req_ch.last       = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.block_size = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size: full-scale swing across two blocks
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      drain();
      // lone word: too few blocks
      queue_sample('0, 1'b1);
      drain();
      // size zero acts as one
      write_block_size('0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      drain();
      // trailing partial block dropped
      write_block_size(bae_pkg::BSIZE_W'(3));
      repeat (3) queue_sample(SAMPLE_MIN, 1'b0);
      repeat (3) queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(16'sh0001, 1'b1);
      drain();
      // constant input gives zero deviation
      write_block_size(bae_pkg::BSIZE_W'(4));
      repeat (7) queue_sample(16'sh0100, 1'b0);
      queue_sample(16'sh0100, 1'b1);
      drain();
      // oversize write saturates
      write_block_size('1);
      queue_sample(SAMPLE_MAX, 1'b1);
      drain();
      // size changed part-way through a series
      write_block_size(bae_pkg::BSIZE_W'(2));
      queue_sample(-16'sd1, 1'b0);
      queue_sample(16'sd1, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      drain();
      write_block_size(bae_pkg::BSIZE_W'(1));
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(16'sh0100, 1'b1);
      drain();
      // largest block size, full rate
      write_block_size(bae_pkg::BSIZE_W'(bae_pkg::MAX_BLOCK));
      send_gap_max = 0;
      recv_gap_max = 0;
      send_series(0, 8, 1'b1);
      drain();

      random_start = queued_items;
      while (queued_items - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       new_size = '0;
            1:       new_size = '1;
            2:       new_size = bae_pkg::BSIZE_W'($urandom_range(65, 128));
            3, 4, 5: new_size = bae_pkg::BSIZE_W'($urandom_range(9, 24));
            default: new_size = bae_pkg::BSIZE_W'($urandom_range(1, 8));
         endcase
         write_block_size(new_size);
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         if (!hold_request && eff_size() <= 8 &&
             queued_items - random_start > RANDOM_ITEMS / 2) begin
            hold_request = 1'b1;
            send_gap_max = 0;
            repeat (16) send_series(2, 0, 1'b1);
         end
         if (eff_size() > 64) begin
            send_series(eff_size() <= 128 && $urandom_range(0, 3) == 0,
                        $urandom_range(0, 8), 1'b1);
         end else begin
            n_series = $urandom_range(1, 4);
            repeat (n_series) begin
               blocks = $urandom_range(0, (eff_size() > 8) ? 3 : 7);
               tail   = $urandom_range(0, eff_size() - 1);
               send_series(blocks, tail, 1'b1);
            end
            // leave a series open across the next size write
            if ($urandom_range(0, 4) == 0)
               send_series($urandom_range(0, 2), $urandom_range(0, 3), 1'b0);
         end
         drain();
      end

      if (errors == 0 && std_err_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
